### src/owm_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the one-wire bus master slot timer.
// Used by onewire_master_slot_timer_core; no other dependencies.
package owm_pkg;

  localparam int TIMER_BITS_DEF = 10;

  localparam int REG_W     = 10;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  localparam int MODE_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int PHASE_W = 4;
  localparam int BITS_W  = 4;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // register indexes
  localparam logic [REG_IDX_W-1:0] R_RESET_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] R_RELEASE_CHK  = 3'd1;
  localparam logic [REG_IDX_W-1:0] R_PRESENCE_WT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] R_RESET_TAIL   = 3'd3;
  localparam logic [REG_IDX_W-1:0] R_SHORT_LOW    = 3'd4;
  localparam logic [REG_IDX_W-1:0] R_LONG_LOW     = 3'd5;
  localparam logic [REG_IDX_W-1:0] R_WRITE_SLOT   = 3'd6;
  localparam logic [REG_IDX_W-1:0] R_READ_SAMPLE  = 3'd7;

  // register reset values
  localparam logic [REG_W-1:0] RST_RESET_LOW   = 10'd480;
  localparam logic [REG_W-1:0] RST_RELEASE_CHK = 10'd15;
  localparam logic [REG_W-1:0] RST_PRESENCE_WT = 10'd55;
  localparam logic [REG_W-1:0] RST_RESET_TAIL  = 10'd410;
  localparam logic [REG_W-1:0] RST_SHORT_LOW   = 10'd2;
  localparam logic [REG_W-1:0] RST_LONG_LOW    = 10'd60;
  localparam logic [REG_W-1:0] RST_WRITE_SLOT  = 10'd64;
  localparam logic [REG_W-1:0] RST_READ_SAMPLE = 10'd10;

  localparam logic [REG_W-1:0] READ_TAIL_TIME = 10'd50;

  // request modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
  localparam logic [MODE_W-1:0] OP_RESET   = 3'd1;
  localparam logic [MODE_W-1:0] OP_WBIT    = 3'd2;
  localparam logic [MODE_W-1:0] OP_RBIT    = 3'd3;
  localparam logic [MODE_W-1:0] OP_WBYTE   = 3'd4;
  localparam logic [MODE_W-1:0] OP_RBYTE   = 3'd5;

  // phases
  localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
  localparam logic [PHASE_W-1:0] PH_RST_LOW   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_RST_CHECK = 4'd2;
  localparam logic [PHASE_W-1:0] PH_RST_PRES  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_RST_TAIL  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SLOT_LOW  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_WR_REL    = 4'd6;
  localparam logic [PHASE_W-1:0] PH_RD_WAIT   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_RD_TAIL   = 4'd8;

  localparam logic [BITS_W-1:0] BITS_ONE  = 4'd1;
  localparam logic [BITS_W-1:0] BITS_BYTE = 4'd8;

endpackage

### src/onewire_master_slot_timer_core.sv
`timescale 1ns / 1ps
// One-wire bus master slot timer: phase sequencer, slot timer and result register.
// Depends on owm_pkg.
// The result of a request is registered and is on out_* in the cycle after it is accepted.
// Throughput: one request per cycle while in_tready is high; the state update and length compare sit
// between the state registers and the result register.
// in_tready drops only while a result is held and out_tready is low.
// Reset (synchronous, rst_n low): idle phase, counters cleared, timing registers
// back to their defaults, result register empty.
module onewire_master_slot_timer_core #(
  parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] write_data, [8] line_level, [15:9] zero
  input  logic [owm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] mode
  input  logic [owm_pkg::MODE_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] status, [11:4] read_data, [15:12] zero
  output logic [owm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [owm_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [owm_pkg::REG_W-1:0]       cfg_wdata
);

  localparam int CW = (TIMER_BITS > owm_pkg::REG_W) ? TIMER_BITS : owm_pkg::REG_W;
  localparam logic [CW-1:0] TMAX = CW'({TIMER_BITS{1'b1}});

  typedef logic [TIMER_BITS-1:0] tick_t;

  // register value -> phase length: zero acts as one, saturate at timer max
  function automatic tick_t clamp_len(input logic [owm_pkg::REG_W-1:0] v);
    logic [CW-1:0] vx;
    vx = CW'(v);
    if (vx == '0) vx = CW'(1);
    if (vx > TMAX) vx = TMAX;
    return vx[TIMER_BITS-1:0];
  endfunction

  logic [owm_pkg::REG_W-1:0] regs_r [owm_pkg::NUM_REGS];

  logic [owm_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [owm_pkg::MODE_W-1:0]  op_r, op_nxt;
  tick_t                       tick_r, tick_nxt;
  logic [owm_pkg::BYTE_W-1:0]  shift_r, shift_nxt;
  logic [owm_pkg::BITS_W-1:0]  bits_r, bits_nxt;
  logic                        was_high_r, was_high_nxt;
  logic                        pres_r, pres_nxt;

  logic                        out_valid_r;
  logic [owm_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [owm_pkg::MODE_W-1:0] mode;
  logic [owm_pkg::BYTE_W-1:0] wdata;
  logic                       line;

  logic  accept;
  logic  is_write;
  tick_t tick_inc, low_len, slot_len, plen;
  logic  slot_end;
  logic  done;
  logic  status;
  logic [owm_pkg::BYTE_W-1:0] rdata;
  logic [owm_pkg::BITS_W-1:0] bits_dec;
  logic  drive_low;

  assign mode  = in_tuser;
  assign wdata = in_tdata[7:0];
  assign line  = in_tdata[8];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign is_write = (op_r == owm_pkg::OP_WBIT) || (op_r == owm_pkg::OP_WBYTE);
  assign low_len  = (is_write && !shift_r[0]) ? clamp_len(regs_r[owm_pkg::R_LONG_LOW])
                                              : clamp_len(regs_r[owm_pkg::R_SHORT_LOW]);
  assign slot_len = clamp_len(regs_r[owm_pkg::R_WRITE_SLOT]);
  assign tick_inc = tick_r + tick_t'(1);

  always_comb begin
    unique case (phase_r)
      owm_pkg::PH_RST_LOW:   plen = clamp_len(regs_r[owm_pkg::R_RESET_LOW]);
      owm_pkg::PH_RST_CHECK: plen = clamp_len(regs_r[owm_pkg::R_RELEASE_CHK]);
      owm_pkg::PH_RST_PRES:  plen = clamp_len(regs_r[owm_pkg::R_PRESENCE_WT]);
      owm_pkg::PH_RST_TAIL:  plen = clamp_len(regs_r[owm_pkg::R_RESET_TAIL]);
      owm_pkg::PH_SLOT_LOW:  plen = low_len;
      owm_pkg::PH_WR_REL:    plen = (slot_len > low_len) ? slot_len - low_len : tick_t'(1);
      owm_pkg::PH_RD_WAIT:   plen = clamp_len(regs_r[owm_pkg::R_READ_SAMPLE]);
      owm_pkg::PH_RD_TAIL:   plen = clamp_len(owm_pkg::READ_TAIL_TIME);
      default:               plen = tick_t'(1);
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    op_nxt       = op_r;
    tick_nxt     = tick_r;
    shift_nxt    = shift_r;
    bits_nxt     = bits_r;
    was_high_nxt = was_high_r;
    pres_nxt     = pres_r;
    slot_end     = 1'b0;
    done         = 1'b0;
    status       = 1'b0;
    rdata        = '0;
    bits_dec     = '0;

    if (mode != owm_pkg::MODE_TICK) begin
      // command: only taken when idle and a known operation
      if (phase_r == owm_pkg::PH_IDLE && mode <= owm_pkg::OP_RBYTE) begin
        op_nxt       = mode;
        was_high_nxt = 1'b0;
        pres_nxt     = 1'b0;
        tick_nxt     = '0;
        phase_nxt    = owm_pkg::PH_SLOT_LOW;
        case (mode)
          owm_pkg::OP_RESET: begin
            bits_nxt  = '0;
            shift_nxt = '0;
            phase_nxt = owm_pkg::PH_RST_LOW;
          end
          owm_pkg::OP_WBIT: begin
            bits_nxt  = owm_pkg::BITS_ONE;
            shift_nxt = {7'd0, wdata[0]};
          end
          owm_pkg::OP_RBIT: begin
            bits_nxt  = owm_pkg::BITS_ONE;
            shift_nxt = '0;
          end
          owm_pkg::OP_WBYTE: begin
            bits_nxt  = owm_pkg::BITS_BYTE;
            shift_nxt = wdata;
          end
          default: begin
            bits_nxt  = owm_pkg::BITS_BYTE;
            shift_nxt = '0;
          end
        endcase
      end
    end else if (phase_r != owm_pkg::PH_IDLE) begin
      tick_nxt = tick_inc;
      if (tick_inc >= plen) begin
        tick_nxt = '0;
        unique case (phase_r)
          owm_pkg::PH_RST_LOW:   phase_nxt = owm_pkg::PH_RST_CHECK;
          owm_pkg::PH_RST_CHECK: begin
            was_high_nxt = line;
            phase_nxt    = owm_pkg::PH_RST_PRES;
          end
          owm_pkg::PH_RST_PRES: begin
            pres_nxt  = !line;
            phase_nxt = owm_pkg::PH_RST_TAIL;
          end
          owm_pkg::PH_RST_TAIL: begin
            phase_nxt = owm_pkg::PH_IDLE;
            done      = 1'b1;
            status    = !(was_high_r && pres_r);
          end
          owm_pkg::PH_SLOT_LOW:
            phase_nxt = is_write ? owm_pkg::PH_WR_REL : owm_pkg::PH_RD_WAIT;
          owm_pkg::PH_WR_REL: begin
            shift_nxt = shift_r >> 1;
            slot_end  = 1'b1;
          end
          owm_pkg::PH_RD_WAIT: begin
            shift_nxt = {line, shift_r[7:1]};
            phase_nxt = owm_pkg::PH_RD_TAIL;
          end
          owm_pkg::PH_RD_TAIL: slot_end = 1'b1;
          default:             phase_nxt = owm_pkg::PH_IDLE;
        endcase

        if (slot_end) begin
          bits_dec = (bits_r != '0) ? bits_r - owm_pkg::BITS_ONE : bits_r;
          bits_nxt = bits_dec;
          if (bits_dec != '0) begin
            phase_nxt = owm_pkg::PH_SLOT_LOW;
          end else begin
            phase_nxt = owm_pkg::PH_IDLE;
            done      = 1'b1;
            if (op_r == owm_pkg::OP_RBIT) rdata = {7'd0, shift_nxt[7]};
            else if (op_r == owm_pkg::OP_RBYTE) rdata = shift_nxt;
          end
        end
      end
    end

    drive_low = (phase_nxt == owm_pkg::PH_RST_LOW) || (phase_nxt == owm_pkg::PH_SLOT_LOW);
    out_data_nxt = {4'd0, rdata, status, done, (phase_nxt != owm_pkg::PH_IDLE), drive_low};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[owm_pkg::R_RESET_LOW]   <= owm_pkg::RST_RESET_LOW;
      regs_r[owm_pkg::R_RELEASE_CHK] <= owm_pkg::RST_RELEASE_CHK;
      regs_r[owm_pkg::R_PRESENCE_WT] <= owm_pkg::RST_PRESENCE_WT;
      regs_r[owm_pkg::R_RESET_TAIL]  <= owm_pkg::RST_RESET_TAIL;
      regs_r[owm_pkg::R_SHORT_LOW]   <= owm_pkg::RST_SHORT_LOW;
      regs_r[owm_pkg::R_LONG_LOW]    <= owm_pkg::RST_LONG_LOW;
      regs_r[owm_pkg::R_WRITE_SLOT]  <= owm_pkg::RST_WRITE_SLOT;
      regs_r[owm_pkg::R_READ_SAMPLE] <= owm_pkg::RST_READ_SAMPLE;
    end else if (cfg_we) begin
      regs_r[cfg_addr] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= owm_pkg::PH_IDLE;
      op_r        <= '0;
      tick_r      <= '0;
      shift_r     <= '0;
      bits_r      <= '0;
      was_high_r  <= 1'b0;
      pres_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        op_r       <= op_nxt;
        tick_r     <= tick_nxt;
        shift_r    <= shift_nxt;
        bits_r     <= bits_nxt;
        was_high_r <= was_high_nxt;
        pres_r     <= pres_nxt;
      end
      if (accept) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
